>>> design/gbgc_pkg.sv
// ----------------------------------------------------------------------------
// gbgc_pkg: shared definitions for the GB2312 glyph cache
// Field widths, code range limits, status codes and default sizes.
// ----------------------------------------------------------------------------
package gbgc_pkg;

  // Default cache geometry
  localparam int DEF_ENTRIES     = 8;
  localparam int DEF_GLYPH_BYTES = 32;

  // Input field widths
  localparam int CODE_W  = 16;
  localparam int WSEL_W  = 2;
  localparam int WORD_W  = 64;
  localparam int IN_DATA_W  = 88;   // 82 bits of fields, padded to bytes

  // Result field widths
  localparam int STAT_W  = 2;
  localparam int INDEX_W = 14;
  localparam int OFFS_W  = 19;
  localparam int OUT_DATA_W = 104;  // 99 bits of fields, padded to bytes

  // GB2312 byte range and row length
  localparam logic [7:0] CODE_LO  = 8'hA1;
  localparam logic [7:0] CODE_HI  = 8'hFE;
  localparam logic [6:0] ROW_LEN  = 7'd94;

  // Maximum words per glyph held by one entry
  localparam int MAX_WORDS = 4;

  // Action carried in tuser
  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_FILL   = 1'b1
  } action_t;

  // Result status carried in tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_HIT     = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_INVALID = 2'd2
  } status_t;

endpackage

>>> design/gb2312_glyph_cache_core.sv
// ----------------------------------------------------------------------------
// gb2312_glyph_cache_core: fully associative 16x16 glyph cache
// Looks up GB2312 codes against cached tags and streams glyph words on a hit,
// reports glyph index and font file offset on a miss, and takes fill words
// into the entry picked by a round-robin replacement pointer.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata fields (low bit up)                     tuser    tlast
//  in_*     slave      char_code, word_select, fill_word, pad         action   -
//  out_*    master     glyph_index, byte_offset, glyph_word,          status   last
//                      word_number, pad
//
//  A transaction lands in an input register, then one pass of compare and
//  index logic loads the result register. Miss and invalid items give one
//  result each, a hit WORDS results (one glyph word per cycle while the
//  result port is not stalled, read from the glyph memory port). Fills give
//  none. Reset clears the valid bits and the replacement pointer. A stalled
//  result port holds a lookup in the input register; fills still drain.
//
module gb2312_glyph_cache_core #(
  parameter int ENTRIES     = gbgc_pkg::DEF_ENTRIES,
  parameter int GLYPH_BYTES = gbgc_pkg::DEF_GLYPH_BYTES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // char_code[15:0], word_select[17:16], fill_word[81:18], zero pad
  input  logic [gbgc_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // glyph_index[13:0], byte_offset[32:14], glyph_word[96:33],
  // word_number[98:97], zero pad
  output logic [gbgc_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [gbgc_pkg::STAT_W-1:0]     out_tuser,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  localparam int ENTRY_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORDS_RAW = GLYPH_BYTES / 8;
  localparam int WORDS     = (WORDS_RAW < 1) ? 1 :
                             ((WORDS_RAW > gbgc_pkg::MAX_WORDS) ?
                              gbgc_pkg::MAX_WORDS : WORDS_RAW);
  localparam int MEM_DEPTH = ENTRIES * gbgc_pkg::MAX_WORDS;
  localparam int ADDR_W    = ENTRY_W + gbgc_pkg::WSEL_W;
  localparam int PROD_W    = gbgc_pkg::INDEX_W + 8;

  localparam logic [gbgc_pkg::WSEL_W-1:0] LAST_WORD  = gbgc_pkg::WSEL_W'(WORDS - 1);
  localparam logic [ENTRY_W-1:0]          LAST_ENTRY = ENTRY_W'(ENTRIES - 1);
  localparam logic [PROD_W-1:0]           GB_MUL     = PROD_W'(GLYPH_BYTES);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                                in_vld_r,  in_vld_nxt;
  gbgc_pkg::action_t                   act_r;
  logic [gbgc_pkg::CODE_W-1:0]         code_r;
  logic [gbgc_pkg::WSEL_W-1:0]         wsel_r;
  logic [gbgc_pkg::WORD_W-1:0]         fword_r;

  // Cache state
  logic [gbgc_pkg::CODE_W-1:0]         tag_r [ENTRIES];
  logic [ENTRIES-1:0]                  valid_r, valid_nxt;
  logic [ENTRY_W-1:0]                  ptr_r,   ptr_nxt;
  logic [gbgc_pkg::WORD_W-1:0]         glyph_mem [MEM_DEPTH];
  logic [gbgc_pkg::WSEL_W-1:0]         wcnt_r,  wcnt_nxt;

  // Result register
  logic                                out_vld_r, out_vld_nxt;
  gbgc_pkg::status_t                   stat_r;
  logic [gbgc_pkg::INDEX_W-1:0]        idx_r;
  logic [gbgc_pkg::OFFS_W-1:0]         offs_r;
  logic [gbgc_pkg::WSEL_W-1:0]         wnum_r;
  logic                                last_r;
  logic [gbgc_pkg::WORD_W-1:0]         word_q_r;

  // Pass logic
  logic                                in_take;
  logic                                out_free;
  logic                                is_fill;
  logic                                fill_ok;
  logic                                fill_wr;
  logic                                fill_end;
  logic                                code_ok;
  logic                                hit;
  logic [ENTRY_W-1:0]                  hit_idx;
  logic                                load;
  logic                                advance;
  logic [6:0]                          row;
  logic [6:0]                          col;
  logic [gbgc_pkg::INDEX_W-1:0]        gidx;
  logic [PROD_W-1:0]                   prod;
  logic [ADDR_W-1:0]                   rd_addr;
  logic [ADDR_W-1:0]                   wr_addr;

  // --------------------------------------------------------------------------
  // Decode the held item
  // --------------------------------------------------------------------------
  assign is_fill  = (act_r == gbgc_pkg::ACT_FILL);
  assign fill_ok  = (wsel_r <= LAST_WORD);
  assign fill_wr  = in_vld_r && is_fill && fill_ok;
  assign fill_end = fill_wr && (wsel_r == LAST_WORD);

  assign code_ok = (code_r[15:8] >= gbgc_pkg::CODE_LO) && (code_r[15:8] <= gbgc_pkg::CODE_HI)
                && (code_r[7:0]  >= gbgc_pkg::CODE_LO) && (code_r[7:0]  <= gbgc_pkg::CODE_HI);

  // Compare all valid tags; lowest matching entry wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int e = ENTRIES - 1; e >= 0; e--) begin
      if (valid_r[e] && (tag_r[e] == code_r)) begin
        hit     = 1'b1;
        hit_idx = ENTRY_W'(e);
      end
    end
  end

  // Glyph index and file offset for a miss
  assign row  = 7'(code_r[15:8] - gbgc_pkg::CODE_LO);
  assign col  = 7'(code_r[7:0]  - gbgc_pkg::CODE_LO);
  assign gidx = gbgc_pkg::INDEX_W'(row) * gbgc_pkg::INDEX_W'(gbgc_pkg::ROW_LEN)
              + gbgc_pkg::INDEX_W'(col);
  assign prod = PROD_W'(gidx) * GB_MUL;

  // --------------------------------------------------------------------------
  // Handshake and sequencing
  // --------------------------------------------------------------------------
  assign out_free = !out_vld_r || out_tready;
  assign load     = in_vld_r && !is_fill && out_free;
  assign advance  = in_vld_r && (is_fill ||
                    (out_free && (!(code_ok && hit) || (wcnt_r == LAST_WORD))));
  assign in_tready = !in_vld_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign rd_addr = {hit_idx, wcnt_r};
  assign wr_addr = {ptr_r, wsel_r};

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end

    // Step through the words of a hit
    wcnt_nxt = wcnt_r;
    if (load && code_ok && hit) begin
      wcnt_nxt = (wcnt_r == LAST_WORD) ? '0 : wcnt_r + 1'b1;
    end

    // Fill writes drop the entry's valid bit until its last word lands
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    if (fill_wr) begin
      valid_nxt[ptr_r] = fill_end;
    end
    if (fill_end) begin
      ptr_nxt = (ptr_r == LAST_ENTRY) ? '0 : ptr_r + 1'b1;
    end

    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      wcnt_r    <= '0;
      valid_r   <= '0;
      ptr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      wcnt_r    <= wcnt_nxt;
      valid_r   <= valid_nxt;
      ptr_r     <= ptr_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    // Capture the incoming transaction
    if (in_take) begin
      act_r   <= gbgc_pkg::action_t'(in_tuser);
      code_r  <= in_tdata[15:0];
      wsel_r  <= in_tdata[17:16];
      fword_r <= in_tdata[81:18];
    end

    // Latch the tag when a glyph completes
    if (fill_end) begin
      tag_r[ptr_r] <= code_r;
    end

    // Build the result
    if (load) begin
      if (!code_ok) begin
        stat_r <= gbgc_pkg::STAT_INVALID;
        idx_r  <= '0;
        offs_r <= '0;
        wnum_r <= '0;
        last_r <= 1'b1;
      end else if (hit) begin
        stat_r <= gbgc_pkg::STAT_HIT;
        idx_r  <= '0;
        offs_r <= '0;
        wnum_r <= wcnt_r;
        last_r <= (wcnt_r == LAST_WORD);
      end else begin
        stat_r <= gbgc_pkg::STAT_MISS;
        idx_r  <= gidx;
        offs_r <= prod[gbgc_pkg::OFFS_W-1:0];
        wnum_r <= '0;
        last_r <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Glyph memory: one write port for fills, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (fill_wr) begin
      glyph_mem[wr_addr] <= fword_r;
    end
    if (load) begin
      word_q_r <= glyph_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Result port
  // --------------------------------------------------------------------------
  assign out_tvalid = out_vld_r;
  assign out_tuser  = stat_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'b0, wnum_r,
                       (stat_r == gbgc_pkg::STAT_HIT) ? word_q_r : {gbgc_pkg::WORD_W{1'b0}},
                       offs_r, idx_r};

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the GB2312 glyph cache
// Walks a short table of lookups and fills (code range edges, miss index
// extremes, duplicate tags, unchecked fill codes), then a long random mix of
// glyph fill runs, lookups of cached codes and stray items. Every result is
// checked field by field against the table or a cycle-free model of the cache kept here.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int ENTRIES     = 8;
  localparam int GLYPH_BYTES = 32;
  localparam int WORDS_RAW   = GLYPH_BYTES / 8;
  localparam int WORDS       = WORDS_RAW < 1 ? 1 :
                               (WORDS_RAW > gbgc_pkg::MAX_WORDS ?
                                gbgc_pkg::MAX_WORDS : WORDS_RAW);
  localparam int RAND_ITEMS  = 405;
  localparam int QUIET_ITEMS = 40;

  typedef struct {
    gbgc_pkg::status_t              status;
    logic [gbgc_pkg::INDEX_W-1:0]   glyph_index;
    logic [gbgc_pkg::OFFS_W-1:0]    byte_offset;
    logic [gbgc_pkg::WORD_W-1:0]    glyph_word;
    logic [1:0]                     word_number;
    logic                           last;
  } glyph_result_t;

  typedef struct {
    gbgc_pkg::action_t              act;
    logic [gbgc_pkg::CODE_W-1:0]    code;
    logic [gbgc_pkg::WSEL_W-1:0]    wsel;
    logic [gbgc_pkg::WORD_W-1:0]    word;
    bit                             has_answer;
    gbgc_pkg::status_t              a_status;
    logic [gbgc_pkg::INDEX_W-1:0]   a_index;
    logic [gbgc_pkg::OFFS_W-1:0]    a_offset;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic [gbgc_pkg::IN_DATA_W-1:0]    in_tdata = '0;
  logic                              in_tuser = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [gbgc_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic [gbgc_pkg::STAT_W-1:0]       out_tuser;
  logic                              out_tlast;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;

  // Cache image kept alongside the block
  logic [gbgc_pkg::CODE_W-1:0]       tag_mem [ENTRIES];
  bit                                tag_written [ENTRIES];
  bit                                entry_valid [ENTRIES];
  logic [gbgc_pkg::WORD_W-1:0]       glyph_mem [ENTRIES][gbgc_pkg::MAX_WORDS];
  bit                                word_written [ENTRIES][gbgc_pkg::MAX_WORDS];
  int                                repl_ptr = 0;

  glyph_result_t          glyph_results_due [$];
  int                     mismatch_count = 0;
  bit                     idle_on = 1'b1;
  int                     stall_left = 0;

  // Directed table: code range edges, miss index extremes, duplicate tags
  stim_row_t dir_rows [25] = '{
    '{gbgc_pkg::ACT_LOOKUP, 16'h0000, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFFFF, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hA0A1, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hA1A0, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFFFE, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFEFF, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hA1A1, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_MISS, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFEFE, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_MISS,
      14'd8835, 19'd282720},
    '{gbgc_pkg::ACT_LOOKUP, 16'hA1FE, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_MISS,
      14'd93, 19'd2976},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFEA1, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_MISS,
      14'd8742, 19'd279744},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd1, 64'h0000_0000_0000_0000, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd2, 64'h5555_5555_5555_5555, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd3, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hB0C4, 2'd0, 64'h0, 1'b0, gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd0, 64'h0123_4567_89AB_CDEF, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd1, 64'hFEDC_BA98_7654_3210, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd2, 64'h8000_0000_0000_0001, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hB0C4, 2'd3, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hB0C4, 2'd0, 64'h0, 1'b0, gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hFFFF, 2'd0, 64'h1111_2222_3333_4444, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hFFFF, 2'd1, 64'h5555_6666_7777_8888, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hFFFF, 2'd2, 64'h9999_AAAA_BBBB_CCCC, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_FILL, 16'hFFFF, 2'd3, 64'hDDDD_EEEE_FFFF_0000, 1'b0,
      gbgc_pkg::STAT_HIT, 14'd0, 19'd0},
    '{gbgc_pkg::ACT_LOOKUP, 16'hFFFF, 2'd0, 64'h0, 1'b1, gbgc_pkg::STAT_INVALID, 14'd0, 19'd0}
  };

  gb2312_glyph_cache_core #(
    .ENTRIES     (ENTRIES),
    .GLYPH_BYTES (GLYPH_BYTES)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the cache image by one item and queue the results it causes
  function automatic void predict_glyph_results(gbgc_pkg::action_t act,
                                                logic [gbgc_pkg::CODE_W-1:0] code,
                                                logic [gbgc_pkg::WSEL_W-1:0] wsel,
                                                logic [gbgc_pkg::WORD_W-1:0] word);
    glyph_result_t r;
    int hit_entry;
    int row;
    int col;
    int idx;
    if (act == gbgc_pkg::ACT_FILL) begin
      if (int'(wsel) >= WORDS) return;
      glyph_mem[repl_ptr][wsel] = word;
      word_written[repl_ptr][wsel] = 1'b1;
      entry_valid[repl_ptr] = 1'b0;
      if (int'(wsel) == WORDS - 1) begin
        tag_mem[repl_ptr] = code;
        tag_written[repl_ptr] = 1'b1;
        entry_valid[repl_ptr] = 1'b1;
        repl_ptr = (repl_ptr + 1) % ENTRIES;
      end
      return;
    end
    if (code[15:8] < gbgc_pkg::CODE_LO || code[15:8] > gbgc_pkg::CODE_HI ||
        code[7:0] < gbgc_pkg::CODE_LO || code[7:0] > gbgc_pkg::CODE_HI) begin
      r = '{gbgc_pkg::STAT_INVALID, '0, '0, '0, '0, 1'b1};
      glyph_results_due.push_back(r);
      return;
    end
    // Lowest matching entry wins
    hit_entry = -1;
    for (int e = ENTRIES - 1; e >= 0; e--)
      if (entry_valid[e] && tag_mem[e] == code) hit_entry = e;
    if (hit_entry >= 0) begin
      for (int w = 0; w < WORDS; w++) begin
        r = '{gbgc_pkg::STAT_HIT, '0, '0, glyph_mem[hit_entry][w], 2'(w), w == WORDS - 1};
        glyph_results_due.push_back(r);
      end
      return;
    end
    row = int'(code[15:8]) - int'(gbgc_pkg::CODE_LO);
    col = int'(code[7:0]) - int'(gbgc_pkg::CODE_LO);
    idx = row * int'(gbgc_pkg::ROW_LEN) + col;
    r = '{gbgc_pkg::STAT_MISS, gbgc_pkg::INDEX_W'(idx),
          gbgc_pkg::OFFS_W'(idx * GLYPH_BYTES), '0, '0, 1'b1};
    glyph_results_due.push_back(r);
  endfunction

  // Present one item, optionally after an idle burst, and hold until accepted
  task automatic send_glyph_item(gbgc_pkg::action_t act, logic [gbgc_pkg::CODE_W-1:0] code,
                                 logic [gbgc_pkg::WSEL_W-1:0] wsel,
                                 logic [gbgc_pkg::WORD_W-1:0] word);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(gbgc_pkg::IN_DATA_W - gbgc_pkg::CODE_W - gbgc_pkg::WSEL_W -
                    gbgc_pkg::WORD_W){1'b0}}, word, wsel, code};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [gbgc_pkg::CODE_W-1:0] random_valid_code();
    return {8'($urandom_range(gbgc_pkg::CODE_HI, gbgc_pkg::CODE_LO)),
            8'($urandom_range(gbgc_pkg::CODE_HI, gbgc_pkg::CODE_LO))};
  endfunction

  // Stimulus: directed table, then random fill runs and lookups
  initial begin
    gbgc_pkg::action_t            act;
    logic [gbgc_pkg::CODE_W-1:0]  code;
    logic [gbgc_pkg::WSEL_W-1:0]  wsel;
    logic [gbgc_pkg::WORD_W-1:0]  word;
    logic [gbgc_pkg::CODE_W-1:0]  fill_code;
    int                           fill_step;
    int                           pick;
    int                           e;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_glyph_item(dir_rows[i].act, dir_rows[i].code, dir_rows[i].wsel, dir_rows[i].word);
      if (dir_rows[i].has_answer)
        glyph_results_due.push_back('{dir_rows[i].a_status, dir_rows[i].a_index,
                                      dir_rows[i].a_offset, '0, '0, 1'b1});
      else
        predict_glyph_results(dir_rows[i].act, dir_rows[i].code, dir_rows[i].wsel,
                              dir_rows[i].word);
    end

    fill_step = 0;
    fill_code = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == RAND_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      // Hold the sender until every queued result has drained
      if (n == RAND_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (glyph_results_due.size() != 0);
      end
      word = {$urandom, $urandom};
      wsel = '0;
      e = $urandom_range(0, ENTRIES - 1);
      if (fill_step != 0 && $urandom_range(0, 4) != 0) begin
        act = gbgc_pkg::ACT_FILL;
        code = fill_code;
        wsel = gbgc_pkg::WSEL_W'(fill_step);
        fill_step = (fill_step + 1) % WORDS;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // Open a glyph fill run, now and then reusing a cached code
          if (tag_written[e] && $urandom_range(0, 5) == 0) fill_code = tag_mem[e];
          else fill_code = random_valid_code();
          act = gbgc_pkg::ACT_FILL;
          code = fill_code;
          fill_step = 1 % WORDS;
        end else if (pick < 70) begin
          act = gbgc_pkg::ACT_LOOKUP;
          code = tag_written[e] ? tag_mem[e] : random_valid_code();
        end else if (pick < 82) begin
          act = gbgc_pkg::ACT_LOOKUP;
          code = random_valid_code();
        end else if (pick < 90) begin
          act = gbgc_pkg::ACT_LOOKUP;
          code = gbgc_pkg::CODE_W'($urandom);
        end else begin
          act = gbgc_pkg::ACT_FILL;
          code = gbgc_pkg::CODE_W'($urandom);
          wsel = gbgc_pkg::WSEL_W'($urandom_range(0, 3));
        end
      end
      // Never close an entry whose earlier words were not all written
      if (act == gbgc_pkg::ACT_FILL && int'(wsel) == WORDS - 1)
        for (int w = WORDS - 2; w >= 0; w--)
          if (!word_written[repl_ptr][w]) wsel = gbgc_pkg::WSEL_W'(w);
      send_glyph_item(act, code, wsel, word);
      predict_glyph_results(act, code, wsel, word);
    end
    in_tvalid <= 1'b0;

    // Drain, then wait for stray results
    for (int i = 0; i < 2000 && glyph_results_due.size() != 0; i++) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatch_count += glyph_results_due.size();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    glyph_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (glyph_results_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: status %0d data %h last %0b",
                   out_tuser, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        exp_r = glyph_results_due.pop_front();
        if (out_tuser !== exp_r.status || out_tdata[13:0] !== exp_r.glyph_index ||
            out_tdata[32:14] !== exp_r.byte_offset || out_tdata[96:33] !== exp_r.glyph_word ||
            out_tdata[98:97] !== exp_r.word_number || out_tlast !== exp_r.last) begin
          if (mismatch_count < 10) begin
            $display("result mismatch: expected status %0d index %0d offset %0d word %h num %0d last %0b",
                     exp_r.status, exp_r.glyph_index, exp_r.byte_offset, exp_r.glyph_word,
                     exp_r.word_number, exp_r.last);
            $display("                 got status %0d index %0d offset %0d word %h num %0d last %0b",
                     out_tuser, out_tdata[13:0], out_tdata[32:14], out_tdata[96:33],
                     out_tdata[98:97], out_tlast);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
design/gbgc_pkg.sv
design/gb2312_glyph_cache_core.sv
verif/tb_top.sv
